>>> hdl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, constants and ring-index helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    // ring size and derived widths
    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // word field widths
    localparam int REQ_W         = 3;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 7;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DUMP       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_DUMP
    } state_t;

    // fold a sum below twice the ring size back into the ring
    function automatic logic [IDX_W-1:0] dq_wrap(input logic [IDX_W:0] sum);
        logic [IDX_W:0] red;
        red = (sum >= (IDX_W+1)'(DEPTH)) ? sum - (IDX_W+1)'(DEPTH) : sum;
        return red[IDX_W-1:0];
    endfunction

    // ring slot at an offset from a base slot
    function automatic logic [IDX_W-1:0] dq_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] offs);
        return dq_wrap({1'b0, base} + {1'b0, offs});
    endfunction

    // ring slot just before a base slot
    function automatic logic [IDX_W-1:0] dq_dec(input logic [IDX_W-1:0] base);
        return (base == '0) ? IDX_W'(DEPTH - 1) : base - 1'b1;
    endfunction

endpackage

>>> hdl/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values kept in a ring buffer in one RAM.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake           payload
//  s_        in    s_valid / s_ready   s_req_type, s_push_value
//  m_        out   m_valid / m_ready   m_result_value, m_status,
//                                      m_entry_count, m_last_result
//
//  push, and any request that meets a full or empty queue: answered straight from the word,
//  so a new word can follow at once; pop: the RAM read is registered, then the result in ST_POP
//  dump: one entry per cycle through the single read port while m_ is not stalled
//  reset clears state, front slot, count, dump walk and m_valid; the entry RAM is not cleared
//  a stalled m_ stage holds the block: no new word and no further dump reads
//
module double_ended_queue (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [dq_pkg::REQ_W-1:0]             s_req_type,
    input  logic signed [dq_pkg::VALUE_W-1:0]    s_push_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [dq_pkg::VALUE_W-1:0]    m_result_value,
    output logic [dq_pkg::STATUS_W-1:0]          m_status,
    output logic [dq_pkg::ENTRY_COUNT_W-1:0]     m_entry_count,
    output logic                                 m_last_result
);

    import dq_pkg::*;

    state_t state_reg, state_next;

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] left_reg, left_next;

    logic                     out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]       out_value_reg, out_value_next;
    logic [STATUS_W-1:0]      out_status_reg, out_status_next;
    logic [ENTRY_COUNT_W-1:0] out_count_reg, out_count_next;
    logic                     out_last_reg, out_last_next;

    logic                     out_free;
    logic                     accept;
    logic                     is_full;
    logic                     is_empty;
    logic [CNT_W-1:0]         cnt_dec;

    logic                     load;
    logic [VALUE_W-1:0]       load_value;
    logic [STATUS_W-1:0]      load_status;
    logic [CNT_W-1:0]         load_count;
    logic                     load_last;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic                     ram_re;
    logic [IDX_W-1:0]         ram_raddr;
    logic [VALUE_W-1:0]       ram_rdata;

    // entry storage
    dq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (s_push_value),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // handshake and queue flags
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign is_full  = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty = (cnt_reg == '0);
    assign cnt_dec  = cnt_reg - 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && !is_empty) begin
                    if (s_req_type == REQ_DUMP) begin
                        state_next = ST_DUMP;
                    end else if (s_req_type == REQ_POP_FRONT ||
                                 s_req_type == REQ_POP_BACK) begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP: begin
                if (out_free && left_reg == '0) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // pointer updates, RAM access and result words
    always_comb begin
        front_next  = front_reg;
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        left_next   = left_reg;
        ram_we      = 1'b0;
        ram_waddr   = front_reg;
        ram_re      = 1'b0;
        ram_raddr   = front_reg;
        load        = 1'b0;
        load_value  = '0;
        load_status = STAT_OK;
        load_count  = cnt_reg;
        load_last   = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_req_type)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                            load = 1'b1;
                            if (is_full) begin
                                load_status = STAT_FULL;
                            end else begin
                                ram_we = 1'b1;
                                if (s_req_type == REQ_PUSH_FRONT) begin
                                    front_next = dq_dec(front_reg);
                                    ram_waddr  = dq_dec(front_reg);
                                end else begin
                                    ram_waddr = dq_add(front_reg, cnt_reg[IDX_W-1:0]);
                                end
                                cnt_next   = cnt_reg + 1'b1;
                                load_count = cnt_reg + 1'b1;
                            end
                        end
                        REQ_DUMP: begin
                            if (is_empty) begin
                                load        = 1'b1;
                                load_status = STAT_EMPTY;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = front_reg;
                                ptr_next  = dq_add(front_reg, IDX_W'(1));
                                left_next = cnt_dec[IDX_W-1:0];
                            end
                        end
                        REQ_POP_FRONT: begin
                            if (is_empty) begin
                                load        = 1'b1;
                                load_status = STAT_EMPTY;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = front_reg;
                                front_next = dq_add(front_reg, IDX_W'(1));
                                cnt_next   = cnt_dec;
                            end
                        end
                        REQ_POP_BACK: begin
                            if (is_empty) begin
                                load        = 1'b1;
                                load_status = STAT_EMPTY;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = dq_add(front_reg, cnt_dec[IDX_W-1:0]);
                                cnt_next  = cnt_dec;
                            end
                        end
                        default: begin
                            // unknown request codes are dropped silently
                        end
                    endcase
                end
            end
            ST_POP: begin
                if (out_free) begin
                    load       = 1'b1;
                    load_value = ram_rdata;
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    load       = 1'b1;
                    load_value = ram_rdata;
                    load_last  = (left_reg == '0);
                    if (left_reg != '0) begin
                        ram_re    = 1'b1;
                        ram_raddr = ptr_reg;
                        ptr_next  = dq_add(ptr_reg, IDX_W'(1));
                        left_next = left_reg - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // output register next values
    always_comb begin
        out_valid_next  = out_valid_reg && !m_ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        if (load) begin
            out_valid_next  = 1'b1;
            out_value_next  = load_value;
            out_status_next = load_status;
            out_count_next  = ENTRY_COUNT_W'(load_count);
            out_last_next   = load_last;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge aclk) begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_result_value = $signed(out_value_reg);
    assign m_status       = out_status_reg;
    assign m_entry_count  = out_count_reg;
    assign m_last_result  = out_last_reg;

    // count never passes the ring size
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count above ring size");

    // new words are taken only when no pop or dump is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("word accepted while busy");

    // a successful push grows the queue by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_full &&
         (s_req_type == REQ_PUSH_FRONT || s_req_type == REQ_PUSH_BACK))
        |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("push did not update count");

    // a dump walk leaves the queue untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DUMP |=> $stable(cnt_reg) && $stable(front_reg))
        else $error("dump changed queue state");

    // full status only reported with a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_FULL) |-> m_entry_count == ENTRY_COUNT_W'(DEPTH))
        else $error("full status with room left");

endmodule
